// ===== rtl/lpgc_pkg.sv =====
// Package for the linear-probing group-count hash table.
// Holds table geometry, result codes, state encoding and the command and
// status structs between the controller and the datapath. No dependencies.
`default_nettype none

package lpgc_pkg;

  // Table geometry: the slot index wraps as a power-of-two counter.
  localparam int unsigned TABLE_SIZE = 1024;
  localparam int unsigned SLOT_W     = $clog2(TABLE_SIZE);
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned ENTRY_W    = KEY_W + COUNT_W;
  localparam int unsigned PROD_W     = 2 * KEY_W;

  // 64-bit Fibonacci multiplier, split into halves for 32x32 products.
  localparam logic [63:0]      FIB_MULT = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [KEY_W-1:0] FIB_LO   = FIB_MULT[31:0];
  localparam logic [KEY_W-1:0] FIB_HI   = FIB_MULT[63:32];

  // Configuration port.
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_HASH_MODE = '0;

  localparam logic OP_INSERT = 1'b0;

  typedef enum logic [2:0] {
    ST_EXISTING  = 3'd0,
    ST_NEW       = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_RESERVED  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH_LO,
    S_HASH_HI,
    S_HASH_SUM,
    S_PROBE,
    S_RESV
  } state_e;

  // Controller -> datapath.
  typedef struct packed {
    logic    in_ready;
    logic    capture;
    logic    load_home_low;
    logic    mul_lo;
    logic    mul_hi;
    logic    load_home_fib;
    logic    advance;
    logic    clr_we;
    logic    write;
    logic    emit;
    status_e res;
  } lpgc_cmd_t;

  // Datapath -> controller.
  typedef struct packed {
    logic in_valid;
    logic in_key_zero;
    logic hash_mode;
    logic hit;
    logic empty;
    logic is_insert;
    logic last_probe;
    logic clr_last;
    logic out_free;
  } lpgc_stat_t;

endpackage

`default_nettype wire

// ===== rtl/lpgc_in_if.sv =====
// Input channel of the group-count table: valid/ready plus opcode and key.
// Depends on lpgc_pkg for the key width.
`default_nettype none

interface lpgc_in_if;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [lpgc_pkg::KEY_W-1:0] key;

  modport source (output valid, output opcode, output key, input ready);
  modport sink   (input valid, input opcode, input key, output ready);
endinterface

`default_nettype wire

// ===== rtl/lpgc_out_if.sv =====
// Result channel of the group-count table: valid/ready plus count and status.
// Depends on lpgc_pkg for the count width.
`default_nettype none

interface lpgc_out_if;
  logic                        valid;
  logic                        ready;
  logic [lpgc_pkg::COUNT_W-1:0] count;
  logic [2:0]                  status;

  modport source (output valid, output count, output status, input ready);
  modport sink   (input valid, input count, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/lpgc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lpgc_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/lpgc_datapath.sv =====
// Datapath of the group-count table: item capture, home-slot hash,
// probe pointer, slot RAM and result register. Depends on lpgc_pkg,
// lpgc_in_if, lpgc_out_if and lpgc_ram.
`default_nettype none

module lpgc_datapath (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                hash_mode_i,
  input  wire lpgc_pkg::lpgc_cmd_t  cmd_i,
  output lpgc_pkg::lpgc_stat_t      stat_o,
  lpgc_in_if.sink                   in_i,
  lpgc_out_if.source                out_o
);
  import lpgc_pkg::*;

  logic                op_q;
  logic [KEY_W-1:0]    key_q;
  logic [PROD_W-1:0]   mul_q, mul_d;
  logic [KEY_W-1:0]    hi_q;
  logic [KEY_W-1:0]    hsum;
  logic [SLOT_W-1:0]   pos_q, pos_d;
  logic [SLOT_W-1:0]   probe_q;
  logic [SLOT_W-1:0]   clr_q;
  logic [ENTRY_W-1:0]  rdata;
  logic [KEY_W-1:0]    rd_key;
  logic [COUNT_W-1:0]  rd_count;
  logic [COUNT_W-1:0]  inc_count;
  logic [COUNT_W-1:0]  new_count;
  logic [COUNT_W-1:0]  res_count;
  logic                ram_we;
  logic [SLOT_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic                out_valid_q;
  logic [COUNT_W-1:0]  out_count_q;
  status_e             out_status_q;

  assign in_i.ready = cmd_i.in_ready;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= in_i.opcode;
      key_q <= in_i.key;
    end
  end

  // Fibonacci hash: bits [63:32] of key*FIB_MULT from two 32x32 products.
  assign mul_d = PROD_W'(key_q) * PROD_W'(cmd_i.mul_hi ? FIB_HI : FIB_LO);
  assign hsum  = hi_q + mul_q[KEY_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_lo || cmd_i.mul_hi) begin
      mul_q <= mul_d;
    end
    if (cmd_i.mul_hi) begin
      hi_q <= mul_q[PROD_W-1:KEY_W];
    end
  end

  // Probe pointer; the RAM reads at the next pointer so data lines up.
  always_comb begin
    pos_d = pos_q;
    if (cmd_i.load_home_low) begin
      pos_d = in_i.key[SLOT_W-1:0];
    end else if (cmd_i.load_home_fib) begin
      pos_d = hsum[KEY_W-1 -: SLOT_W];
    end else if (cmd_i.advance) begin
      pos_d = pos_q + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      probe_q <= '0;
      clr_q   <= '0;
    end else begin
      pos_q <= pos_d;
      if (cmd_i.capture) begin
        probe_q <= '0;
      end else if (cmd_i.advance) begin
        probe_q <= probe_q + SLOT_W'(1);
      end
      if (cmd_i.clr_we) begin
        clr_q <= clr_q + SLOT_W'(1);
      end
    end
  end

  assign rd_key    = rdata[KEY_W-1:0];
  assign rd_count  = rdata[ENTRY_W-1:KEY_W];
  assign inc_count = (rd_count == '1) ? rd_count : rd_count + COUNT_W'(1);
  assign new_count = (cmd_i.res == ST_NEW) ? COUNT_W'(1) : inc_count;

  always_comb begin
    unique case (cmd_i.res)
      ST_EXISTING: res_count = (op_q == OP_INSERT) ? inc_count : rd_count;
      ST_NEW:      res_count = COUNT_W'(1);
      default:     res_count = '0;
    endcase
  end

  assign ram_we    = cmd_i.clr_we || cmd_i.write;
  assign ram_waddr = cmd_i.clr_we ? clr_q : pos_q;
  assign ram_wdata = cmd_i.clr_we ? '0 : {new_count, key_q};

  lpgc_ram #(
    .Width (ENTRY_W),
    .Depth (TABLE_SIZE)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (pos_d),
    .rdata_o (rdata)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_count_q  <= res_count;
      out_status_q <= cmd_i.res;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.count  = out_count_q;
  assign out_o.status = out_status_q;

  always_comb begin
    stat_o.in_valid    = in_i.valid;
    stat_o.in_key_zero = (in_i.key == '0);
    stat_o.hash_mode   = hash_mode_i;
    stat_o.hit         = (rd_key == key_q);
    stat_o.empty       = (rd_key == '0);
    stat_o.is_insert   = (op_q == OP_INSERT);
    stat_o.last_probe  = (probe_q == SLOT_W'(TABLE_SIZE - 1));
    stat_o.clr_last    = (clr_q == SLOT_W'(TABLE_SIZE - 1));
    stat_o.out_free    = !out_valid_q || out_o.ready;
  end

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_o.ready))
    else $error("result overwrote an untaken result");

  a_write_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write |-> (key_q != '0) && (rd_key == key_q || rd_key == '0))
    else $error("slot written that neither matched nor was empty");

  a_clear_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clr_we |-> !cmd_i.write && !cmd_i.in_ready)
    else $error("clearing pass overlapped item work");

endmodule

`default_nettype wire

// ===== rtl/lpgc_ctrl.sv =====
// Controller of the group-count table: clearing pass, hash sequencing,
// probe loop and result issue. Depends on lpgc_pkg.
`default_nettype none

module lpgc_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire lpgc_pkg::lpgc_stat_t stat_i,
  output lpgc_pkg::lpgc_cmd_t       cmd_o
);
  import lpgc_pkg::*;

  state_e state_q, state_d;
  logic   finish;

  assign finish = stat_i.hit || stat_i.empty || stat_i.last_probe;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (stat_i.in_valid) begin
          if (stat_i.in_key_zero) begin
            state_d = S_RESV;
          end else if (stat_i.hash_mode) begin
            state_d = S_HASH_LO;
          end else begin
            state_d = S_PROBE;
          end
        end
      end
      S_HASH_LO:  state_d = S_HASH_HI;
      S_HASH_HI:  state_d = S_HASH_SUM;
      S_HASH_SUM: state_d = S_PROBE;
      S_PROBE: begin
        if (finish && stat_i.out_free) state_d = S_IDLE;
      end
      S_RESV: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.res = ST_RESERVED;
    unique case (state_q)
      S_CLEAR: cmd_o.clr_we = 1'b1;
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (stat_i.in_valid) begin
          cmd_o.capture       = 1'b1;
          cmd_o.load_home_low = !stat_i.in_key_zero && !stat_i.hash_mode;
        end
      end
      S_HASH_LO:  cmd_o.mul_lo = 1'b1;
      S_HASH_HI:  cmd_o.mul_hi = 1'b1;
      S_HASH_SUM: cmd_o.load_home_fib = 1'b1;
      S_PROBE: begin
        if (!finish) begin
          cmd_o.advance = 1'b1;
        end else if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.hit) begin
            cmd_o.res   = ST_EXISTING;
            cmd_o.write = stat_i.is_insert;
          end else if (stat_i.empty) begin
            cmd_o.res   = stat_i.is_insert ? ST_NEW : ST_NOT_FOUND;
            cmd_o.write = stat_i.is_insert;
          end else begin
            cmd_o.res = stat_i.is_insert ? ST_FULL : ST_NOT_FOUND;
          end
        end
      end
      S_RESV: cmd_o.emit = stat_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  a_no_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.advance |-> !stat_i.last_probe)
    else $error("probe advanced past the whole table");

  a_clear_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR && stat_i.clr_last) |=> state_q == S_IDLE)
    else $error("clearing pass did not end at the last slot");

endmodule

`default_nettype wire

// ===== rtl/linear_probe_group_count.sv =====
// Top level of the linear-probing group-count hash table.
// Depends on lpgc_pkg, lpgc_in_if, lpgc_out_if, lpgc_ctrl and lpgc_datapath.
//
// Counts occurrences of 32-bit keys in a 1024-slot open-addressing table.
// An insert (opcode 0) finds the key's home slot and walks forward one slot
// per cycle, wrapping at the end: it bumps the count of a matching slot
// (saturating at all ones, status existing) or claims the first empty slot
// with count 1 (status new); a full table drops the item (status full,
// count 0). A lookup (opcode 1) walks the same way and returns the count, or
// 0 with status not-found on an empty slot or after all slots. Key 0 marks
// an empty slot, so it is rejected with status reserved and count 0. The
// home slot is the key's low 10 bits (hash_mode 0) or the top 10 bits of the
// upper word of the 64-bit Fibonacci product (hash_mode 1). After reset the
// block runs a clearing pass over all 1024 slots of the slot RAM and takes
// no item meanwhile; register writes are taken at any time. Per item: the
// accept state, then in hash_mode 1 S_HASH_LO, S_HASH_HI and S_HASH_SUM for
// the two 32x32 multiplies and the hash add, then the probe loop; a reserved
// key goes from accept to S_RESV. The probe loop is paced by the single read
// port of the slot RAM. Items are handled one at a time; the next item is
// accepted while the previous result still waits in the output register.
`default_nettype none

module linear_probe_group_count (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [lpgc_pkg::PADDR_W-1:0] paddr,
  input  wire logic [lpgc_pkg::PDATA_W-1:0] pwdata,
  output logic      [lpgc_pkg::PDATA_W-1:0] prdata,
  output logic                              pready,
  // item channels
  lpgc_in_if.sink                           in_i,
  lpgc_out_if.source                        out_o
);
  import lpgc_pkg::*;

  logic       hash_mode_q;
  logic       reg_sel;
  lpgc_cmd_t  cmd;
  lpgc_stat_t stat;

  // Register file: one register, hash_mode, at byte address 0.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1:2] == REG_HASH_MODE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_mode_q <= 1'b0;
    end else if (psel && penable && pwrite && reg_sel) begin
      // keep only the low bit
      hash_mode_q <= pwdata[0];
    end
  end

  assign prdata = reg_sel ? PDATA_W'(hash_mode_q) : '0;

  lpgc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  lpgc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hash_mode_i (hash_mode_q),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_i        (in_i),
    .out_o       (out_o)
  );

  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.mul_lo || cmd.load_home_low) |-> $stable(hash_mode_q))
    else $error("hash mode changed while an item was hashed");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking bench for linear_probe_group_count: drives insert and lookup items,
// predicts every result with an in-bench hash table and checks it field by field.
// Depends on lpgc_pkg, lpgc_in_if, lpgc_out_if and the RTL top level.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lpgc_pkg::*;

  localparam logic OP_LOOKUP = ~OP_INSERT;

  // Register map: hash_mode is register 0; register 1 does not exist.
  localparam logic [PADDR_W-1:0] ADDR_HASH_MODE = 3'd0;
  localparam logic [PADDR_W-1:0] ADDR_NO_REG    = 3'd4;

  // The longest quiet stretch of a correct run is the clearing pass after reset,
  // or a full-table walk of 1024 probes plus stalls.
  localparam int QUIET_LIMIT  = 10000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 290;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    status_e            status;
  } tally_t;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  lpgc_in_if  in_ch ();
  lpgc_out_if out_ch ();

  linear_probe_group_count dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_ch),
    .out_o   (out_ch)
  );

  // Shadow of the slot store and the hash mode register.
  logic [KEY_W-1:0]   slot_key [TABLE_SIZE];
  logic [COUNT_W-1:0] slot_cnt [TABLE_SIZE];
  logic               hash_mode_q;

  tally_t expected_tallies [$];
  int     errors;
  bit     steady;  // when set, neither side idles

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [SLOT_W-1:0] home_of(input logic [KEY_W-1:0] key);
    logic [63:0] prod;
    prod = {32'd0, key} * FIB_MULT;
    // Fibonacci mode: the upper word scaled by the table size is its top 10 bits.
    return hash_mode_q ? prod[63:64-SLOT_W] : key[SLOT_W-1:0];
  endfunction

  // Count a key in, or look it up, against the shadow table.
  function automatic tally_t tally_key(input logic op, input logic [KEY_W-1:0] key);
    tally_t           r;
    logic [SLOT_W-1:0] pos;
    r.count = '0;
    if (key == '0) begin
      r.status = ST_RESERVED;
      return r;
    end
    r.status = (op == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
    pos = home_of(key);
    for (int n = 0; n < TABLE_SIZE; n++) begin
      if (slot_key[pos] == key) begin
        // saturate at all ones; status stays existing
        if (op == OP_INSERT && slot_cnt[pos] != {COUNT_W{1'b1}})
          slot_cnt[pos] = slot_cnt[pos] + 1'b1;
        r.count  = slot_cnt[pos];
        r.status = ST_EXISTING;
        break;
      end
      if (slot_key[pos] == '0) begin
        if (op == OP_INSERT) begin
          slot_key[pos] = key;
          slot_cnt[pos] = 1;
          r.count       = 1;
          r.status      = ST_NEW;
        end
        break;
      end
      pos = pos + 1'b1;  // wraps at the table end
    end
    return r;
  endfunction

  function automatic int draw_wait();
    return steady ? 0 : $urandom_range(0, 4);
  endfunction

  // Offer one item after a random gap; predict its result once it is accepted.
  task automatic send_item(input logic op, input logic [KEY_W-1:0] key);
    int gap;
    gap = draw_wait();
    repeat (gap) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_ch.valid  <= 1'b1;
    in_ch.opcode <= op;
    in_ch.key    <= key;
    do @(posedge clk_i); while (!in_ch.ready);
    expected_tallies.push_back(tally_key(op, key));
  endtask

  // Drop valid, wait until every expected result is back, then let the block settle.
  task automatic drain_results();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (expected_tallies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // APB write: setup then access; registers change only while the block is idle.
  task automatic write_register(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    drain_results();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr[PADDR_W-1:2] == REG_HASH_MODE)
      hash_mode_q = data[0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Result sink: stall a random number of cycles before taking each result.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = draw_wait();
      repeat (stall) begin
        @(negedge clk_i);
        out_ch.ready <= 1'b0;
      end
      @(negedge clk_i);
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    tally_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_tallies.size() == 0) begin
        $error("unexpected result: count %0d, status %0d", out_ch.count, out_ch.status);
        errors++;
      end else begin
        want = expected_tallies.pop_front();
        if (out_ch.count !== want.count) begin
          $error("count mismatch: expected %0d, got %0d", want.count, out_ch.count);
          errors++;
        end
        if (out_ch.status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, out_ch.status);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run when neither channel moves for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Key 0 is the empty marker: both operations must be rejected, table untouched.
  task automatic test_reserved_key();
    send_item(OP_INSERT, '0);
    send_item(OP_LOOKUP, '0);
    send_item(OP_LOOKUP, 32'd1);
  endtask

  // Low-bits hashing: new and existing entries, misses, collision chains and wrap.
  task automatic test_insert_and_lookup();
    send_item(OP_INSERT, 32'd1);
    send_item(OP_INSERT, 32'd1);
    send_item(OP_LOOKUP, 32'd1);
    send_item(OP_LOOKUP, 32'd2);
    send_item(OP_INSERT, 32'hFFFF_FFFF);
    send_item(OP_LOOKUP, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 32'h8000_0000);
    // three keys sharing home slot 5, then a miss that walks the whole chain
    send_item(OP_INSERT, 32'd5);
    send_item(OP_INSERT, 32'd5 + 32'd1024);
    send_item(OP_INSERT, 32'd5 + 32'd2048);
    send_item(OP_LOOKUP, 32'd5 + 32'd2048);
    send_item(OP_LOOKUP, 32'd5 + 32'd3072);
    // slot 1023 is taken by 0xFFFFFFFF, so the chain wraps into slot 0 and beyond
    send_item(OP_INSERT, 32'd2047);
    send_item(OP_INSERT, 32'd1023);
    send_item(OP_LOOKUP, 32'd1023);
    drain_results();
  endtask

  // Fibonacci hashing, the ignored register index and the masked upper data bits.
  task automatic test_hash_mode();
    write_register(ADDR_HASH_MODE, 32'd1);
    send_item(OP_INSERT, 32'hFFFF_FFFF);
    send_item(OP_LOOKUP, 32'd1);
    send_item(OP_INSERT, 32'h0000_0003);
    send_item(OP_LOOKUP, 32'h0000_0003);
    write_register(ADDR_NO_REG, 32'd0);  // no register here: mode stays 1
    send_item(OP_LOOKUP, 32'h0000_0003);
    write_register(ADDR_HASH_MODE, 32'hFFFF_FFFE);  // only bit 0 counts
    send_item(OP_LOOKUP, 32'h0000_0003);
    drain_results();
  endtask

  // Random traffic around a small pool of hot keys so most inserts hit existing
  // entries; keys that share low bits build collision chains in low-bits mode.
  task automatic test_random_traffic(input logic [PDATA_W-1:0] mode_word);
    logic [KEY_W-1:0] pool [48];
    logic [KEY_W-1:0] key;
    logic             op;
    int               pick;
    write_register(ADDR_HASH_MODE, mode_word);
    for (int i = 0; i < 48; i++) begin
      pool[i] = $urandom;
      if (i % 2 == 1)
        pool[i][SLOT_W-1:0] = pool[i-1][SLOT_W-1:0];
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0)
        steady = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      op   = 1'($urandom_range(0, 1));
      if (pick < 5)
        key = '0;
      else if (pick < 25)
        key = $urandom;
      else if (pick < 32)
        key = pool[$urandom_range(0, 47)] ^ ($urandom << SLOT_W);
      else begin
        key = pool[$urandom_range(0, 47)];
        op  = ($urandom_range(0, 9) < 6) ? OP_INSERT : OP_LOOKUP;
      end
      send_item(op, key);
      // now and then hold the sender until every result is back
      if ($urandom_range(0, 99) == 0)
        drain_results();
    end
    steady = 1'b0;
    drain_results();
  endtask

  // Fill every empty slot with a key whose home is that slot, then walk the full
  // table: dropped insert, exhausted lookup, and hits in both hash modes.
  task automatic test_full_table();
    logic [31:0] upper;
    write_register(ADDR_HASH_MODE, 32'd0);
    for (int s = 0; s < TABLE_SIZE; s++) begin
      if (slot_key[s] == '0) begin
        upper = $urandom_range(1, 32'h003F_FFFF);
        send_item(OP_INSERT, {upper[KEY_W-SLOT_W-1:0], s[SLOT_W-1:0]});
      end
    end
    send_item(OP_INSERT, $urandom | 32'd1);
    send_item(OP_LOOKUP, $urandom | 32'd1);
    send_item(OP_INSERT, slot_key[$urandom_range(0, TABLE_SIZE-1)]);
    send_item(OP_LOOKUP, slot_key[$urandom_range(0, TABLE_SIZE-1)]);
    write_register(ADDR_HASH_MODE, 32'd1);
    send_item(OP_INSERT, $urandom | 32'd1);
    send_item(OP_LOOKUP, $urandom | 32'd1);
    send_item(OP_LOOKUP, slot_key[$urandom_range(0, TABLE_SIZE-1)]);
    send_item(OP_INSERT, slot_key[$urandom_range(0, TABLE_SIZE-1)]);
    send_item(OP_INSERT, '0);
    drain_results();
  endtask

  // Saturation needs 2^32 inserts of one key, so only the predictor carries it.
  initial begin
    errors       = 0;
    steady       = 1'b0;
    hash_mode_q  = 1'b0;
    for (int s = 0; s < TABLE_SIZE; s++) begin
      slot_key[s] = '0;
      slot_cnt[s] = '0;
    end
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_ch.valid  = 1'b0;
    in_ch.opcode = OP_INSERT;
    in_ch.key    = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reserved_key();
    test_insert_and_lookup();
    test_hash_mode();
    test_random_traffic(32'd0);
    test_random_traffic(32'd1);
    test_random_traffic(32'hFFFF_FFFF);
    test_random_traffic(32'h8000_0000);
    test_full_table();

    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lpgc_pkg.sv
rtl/lpgc_in_if.sv
rtl/lpgc_out_if.sv
rtl/lpgc_ram.sv
rtl/lpgc_datapath.sv
rtl/lpgc_ctrl.sv
rtl/linear_probe_group_count.sv
dv/tb.sv
